FILE: hdl/llrv_pkg.sv
// ---------------------------------------------------------------------------
// LLR vector ALU package
// Widths, operation and register codes, and the structs shared by the
// lane, merge and top-level modules.
// ---------------------------------------------------------------------------
package llrv_pkg;

	localparam int LANES       = 8;
	localparam int LLR_W       = 8;
	localparam int VEC_W       = 64;
	localparam int OP_W        = 3;
	localparam int CNT_W       = 4;
	localparam int MAG_W       = 7;
	localparam int DOT_W       = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int DOT_LANE_W  = LLR_W + 1;
	localparam int DOT_SUM_W   = DOT_LANE_W + $clog2(LANES) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_SAT_SUM   = 3'd0,
		OP_PROMO_SUM = 3'd1,
		OP_CLAMP     = 3'd2,
		OP_HARD      = 3'd3,
		OP_DOT       = 3'd4
	} llrv_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LLR_MAX    = 2'd0,
		REG_LLR_INF    = 2'd1,
		REG_CLAMP_LOW  = 2'd2,
		REG_CLAMP_HIGH = 2'd3
	} llrv_reg_t;

	typedef struct packed {
		logic        [MAG_W-1:0] llr_max;
		logic        [MAG_W-1:0] llr_inf;
		logic signed [LLR_W-1:0] clamp_low;
		logic signed [LLR_W-1:0] clamp_high;
	} llrv_cfg_t;

	localparam llrv_cfg_t CFG_RESET = '{
		llr_max:    7'd120,
		llr_inf:    7'd127,
		clamp_low:  -8'sd120,
		clamp_high: 8'sd120
	};

	// What one lane hands to the merge stage
	typedef struct packed {
		logic        [LLR_W-1:0]      res;
		logic                         hard;
		logic                         zero;
		logic signed [DOT_LANE_W-1:0] dot;
	} llrv_lane_t;

	typedef struct packed {
		logic        [VEC_W-1:0] result_vec;
		logic        [LLR_W-1:0] packed_bits;
		logic                    all_nonzero;
		logic signed [DOT_W-1:0] dot_total;
	} llrv_res_t;

endpackage

FILE: hdl/llrv_if.sv
// ---------------------------------------------------------------------------
// LLR vector ALU channels
// Valid/ready channels for input words, result words and register writes.
// ---------------------------------------------------------------------------
interface llrv_in_if import llrv_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      op;
	logic [VEC_W-1:0]     a_vec;
	logic [VEC_W-1:0]     b_vec;
	logic [CNT_W-1:0]     lane_count;
	logic                 last_item;

	modport source (output valid, op, a_vec, b_vec, lane_count, last_item, input ready);
	modport sink   (input valid, op, a_vec, b_vec, lane_count, last_item, output ready);
endinterface

interface llrv_out_if import llrv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic        [VEC_W-1:0] result_vec;
	logic        [LLR_W-1:0] packed_bits;
	logic                    all_nonzero;
	logic signed [DOT_W-1:0] dot_total;

	modport source (output valid, result_vec, packed_bits, all_nonzero, dot_total,
		input ready);
	modport sink   (input valid, result_vec, packed_bits, all_nonzero, dot_total,
		output ready);
endinterface

interface llrv_cfg_if import llrv_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/llrv_lane.sv
// ---------------------------------------------------------------------------
// LLR vector ALU lane
// One lane: saturating/promotion sum, clamp, hard bit, zero flag and the
// signed contribution to the sign dot product.
// ---------------------------------------------------------------------------
module llrv_lane import llrv_pkg::*; (
	input  llrv_op_t                op,
	input  logic                    lane_valid,
	input  logic signed [LLR_W-1:0] a,
	input  logic signed [LLR_W-1:0] b,
	input  llrv_cfg_t               cfg,
	output llrv_lane_t              lane_out
);

	logic signed [LLR_W:0]   a9;
	logic signed [LLR_W:0]   b9;
	logic signed [LLR_W:0]   sum9;
	logic        [LLR_W:0]   mag_a;
	logic        [LLR_W:0]   mag_b;
	logic        [LLR_W+1:0] mag_s;
	logic        [LLR_W-1:0] inf_pos;
	logic        [LLR_W-1:0] max_pos;
	logic        [LLR_W-1:0] lim;
	logic        [LLR_W-1:0] sum_r;
	logic signed [LLR_W-1:0] clamp_r;

	assign a9      = {a[LLR_W-1], a};
	assign b9      = {b[LLR_W-1], b};
	assign sum9    = a9 + b9;
	assign mag_a   = a9[LLR_W] ? -a9 : a9;
	assign mag_b   = b9[LLR_W] ? -b9 : b9;
	assign mag_s   = sum9[LLR_W] ? -{sum9[LLR_W], sum9} : {sum9[LLR_W], sum9};
	assign inf_pos = {1'b0, cfg.llr_inf};
	assign max_pos = {1'b0, cfg.llr_max};

	always_comb begin
		lim = (op == OP_PROMO_SUM) ? inf_pos : max_pos;
		if (a9 == -b9) begin
			sum_r = '0;
		end else if (mag_a >= {2'b00, cfg.llr_inf}) begin
			sum_r = a[LLR_W-1] ? -inf_pos : inf_pos;
		end else if (mag_b >= {2'b00, cfg.llr_inf}) begin
			sum_r = b[LLR_W-1] ? -inf_pos : inf_pos;
		end else if (mag_s > {3'b000, cfg.llr_max}) begin
			sum_r = sum9[LLR_W] ? -lim : lim;
		end else begin
			sum_r = sum9[LLR_W-1:0];
		end
	end

	// upper bound first, so the lower bound wins when the two cross
	always_comb begin
		clamp_r = a;
		if (clamp_r > cfg.clamp_high) begin
			clamp_r = cfg.clamp_high;
		end
		if (clamp_r < cfg.clamp_low) begin
			clamp_r = cfg.clamp_low;
		end
	end

	always_comb begin
		lane_out = '0;
		if (lane_valid) begin
			unique case (op)
				OP_SAT_SUM, OP_PROMO_SUM: lane_out.res = sum_r;
				OP_CLAMP: lane_out.res = clamp_r;
				OP_HARD: begin
					lane_out.hard = (a <= 0);
					lane_out.zero = (a == 0);
				end
				OP_DOT: lane_out.dot = b[LLR_W-1] ? -a9 : a9;
				default: lane_out = '0;
			endcase
		end
	end

endmodule

FILE: hdl/llrv_merge.sv
// ---------------------------------------------------------------------------
// LLR vector ALU merge stage
// Combines the lane words into one result and keeps the run state: the
// saturating dot accumulator and the zero-seen flag.
// ---------------------------------------------------------------------------
module llrv_merge import llrv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  llrv_op_t   op,
	input  logic       last,
	input  llrv_lane_t lanes [LANES],
	output llrv_res_t  res
);

	logic signed [DOT_W-1:0]     acc_q;
	logic                        zero_seen_q;
	logic signed [DOT_SUM_W-1:0] dot_sum;
	logic        [DOT_W:0]       acc_sum;
	logic signed [DOT_W-1:0]     acc_sat;
	logic                        zero_any;
	logic                        zero_run;

	always_comb begin
		dot_sum  = '0;
		zero_any = 1'b0;
		res      = '0;
		for (int i = 0; i < LANES; i++) begin
			dot_sum  = dot_sum + DOT_SUM_W'(lanes[i].dot);
			zero_any = zero_any | lanes[i].zero;
			res.result_vec[i*LLR_W +: LLR_W] = lanes[i].res;
			res.packed_bits[LLR_W-1-i]       = lanes[i].hard;
		end
		acc_sum = (DOT_W+1)'(acc_q) + (DOT_W+1)'(dot_sum);
		if (acc_sum[DOT_W] != acc_sum[DOT_W-1]) begin
			acc_sat = acc_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
		end else begin
			acc_sat = acc_sum[DOT_W-1:0];
		end
		zero_run        = zero_seen_q | zero_any;
		res.all_nonzero = (op == OP_HARD) ? !zero_run : 1'b0;
		res.dot_total   = (op == OP_DOT) ? acc_sat : '0;
	end

	// run state moves only with a word of its own op; last closes the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			zero_seen_q <= 1'b0;
		end else if (fire) begin
			if (op == OP_HARD) begin
				zero_seen_q <= last ? 1'b0 : zero_run;
			end
			if (op == OP_DOT) begin
				acc_q <= last ? '0 : acc_sat;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_dot_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_DOT && last |=> acc_q == '0)
		else $error("dot accumulator not cleared at end of run");

	a_hard_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_HARD && last |=> !zero_seen_q)
		else $error("zero flag not cleared at end of run");

	a_other_ops_keep_acc: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op != OP_DOT |=> $stable(acc_q))
		else $error("dot accumulator changed by another op");
`endif

endmodule

FILE: hdl/llr_vector_alu.sv
// ---------------------------------------------------------------------------
// LLR vector ALU
// Eight-lane signed 8-bit LLR arithmetic with run state for hard decision
// and sign dot product.
// ---------------------------------------------------------------------------
// Takes one input word per clock while the output is not stalled and returns
// one result word per input word; each accepted word passes through the lane
// stage register and then the output register. Every lane of a word is worked
// on at once by its own lane unit (sum, clamp, hard bit, dot term); the lane
// outputs are registered, then one merge stage packs the lanes, adds the
// lane dot terms into the 32-bit saturating accumulator and registers the
// result. The accumulator and the zero-seen flag in the merge stage are the
// only state carried from word to word, so runs of op 3 or op 4 words also
// go at one word per clock while the output is not stalled. A result waiting
// on the output does not block input until the lane stage is full behind it.
// Registers are written through the cfg channel, which is always ready; write
// them only while no word is in flight.
// ---------------------------------------------------------------------------
module llr_vector_alu import llrv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	llrv_in_if.sink     din,
	llrv_out_if.source  dout,
	llrv_cfg_if.sink    cfg
);

	llrv_cfg_t  cfg_q;
	llrv_lane_t lane_w [LANES];
	llrv_lane_t lane_s1 [LANES];
	llrv_op_t   op_in;
	llrv_op_t   op_s1;
	logic       last_s1;
	logic       valid_s1;
	llrv_res_t  merge_res;
	llrv_res_t  out_q;
	logic       out_valid_q;
	logic       out_open;
	logic       s1_fire;
	logic       in_fire;

	// register writes ---------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (llrv_reg_t'(cfg.index))
				REG_LLR_MAX:    cfg_q.llr_max    <= cfg.data[MAG_W-1:0];
				REG_LLR_INF:    cfg_q.llr_inf    <= cfg.data[MAG_W-1:0];
				REG_CLAMP_LOW:  cfg_q.clamp_low  <= cfg.data;
				REG_CLAMP_HIGH: cfg_q.clamp_high <= cfg.data;
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// handshake: output register opens when empty or being taken -------------
	assign out_open  = !out_valid_q || dout.ready;
	assign s1_fire   = valid_s1 && out_open;
	assign din.ready = !valid_s1 || out_open;
	assign in_fire   = din.valid && din.ready;
	assign op_in     = llrv_op_t'(din.op);

	// lanes -------------------------------------------------------------------
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		llrv_lane u_lane (
			.op         (op_in),
			.lane_valid (din.lane_count > CNT_W'(g)),
			.a          (din.a_vec[g*LLR_W +: LLR_W]),
			.b          (din.b_vec[g*LLR_W +: LLR_W]),
			.cfg        (cfg_q),
			.lane_out   (lane_w[g])
		);
	end

	// lane stage register -----------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			lane_s1 <= lane_w;
			op_s1   <= op_in;
			last_s1 <= din.last_item;
		end
	end

	// merge and run state -----------------------------------------------------
	llrv_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (s1_fire),
		.op     (op_s1),
		.last   (last_s1),
		.lanes  (lane_s1),
		.res    (merge_res)
	);

	// output register: hold while stalled, advance when open ------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_open) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_q <= merge_res;
		end
	end

	assign dout.valid       = out_valid_q;
	assign dout.result_vec  = out_q.result_vec;
	assign dout.packed_bits = out_q.packed_bits;
	assign dout.all_nonzero = out_q.all_nonzero;
	assign dout.dot_total   = out_q.dot_total;

`ifndef NO_ASSERTIONS
	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !dout.ready |=> valid_s1)
		else $error("lane stage word dropped during output stall");

	a_ready_only_blocked_by_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> valid_s1 && out_valid_q && !dout.ready)
		else $error("input blocked without a full pipeline");

	a_out_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		dout.valid && !dout.ready |=> dout.valid && $stable(out_q))
		else $error("result word changed while waiting on the output");
`endif

endmodule
